// ===== rtl/srpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srpc_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned FMT_W  = 2;

  // Target pixel formats
  localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_RGB555 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_BGR565 = 2'd2;

  // Position in the sprite stream
  typedef enum logic [7:0] {
    PH_HDR0  = 8'b0000_0001,
    PH_HDR1  = 8'b0000_0010,
    PH_HDR2  = 8'b0000_0100,
    PH_HDR3  = 8'b0000_1000,
    PH_COUNT = 8'b0001_0000,
    PH_SIZE  = 8'b0010_0000,
    PH_PIXEL = 8'b0100_0000,
    PH_LEAD  = 8'b1000_0000
  } phase_t;

  function automatic logic [WORD_W-1:0] convert_pixel(
    input logic [WORD_W-1:0] c,
    input logic [FMT_W-1:0]  fmt
  );
    logic [WORD_W-1:0] res;
    case (fmt)
      FMT_RGB565: res = c;
      FMT_RGB555: res = {1'b0, c[15:11], c[10:6], c[4:0]};
      // BGR565 and the unused code: swap red and blue
      default:    res = {c[4:0], c[10:5], c[15:11]};
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sprite_run_pixel_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | tdata                | tuser       | tlast
// in_     | slave     | [15:0] data_word     | -           | -
// out_    | master    | [15:0] out_word      | [0] is_pixel | last word of sprite
// cfg_    | write     | [1:0] pixel_format   | -           | -
//
// One word per clock: the parser state and the output register update in the
// cycle a word is accepted, and the result appears on the next cycle.
// in_tready is high whenever the output register is empty or being drained.
// Synchronous active-low reset returns the parser to header word zero,
// clears all counters and selects RGB565 passthrough.
// A stall on out_ holds the result word and stops input acceptance.

module sprite_run_pixel_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] data_word
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] out_word
  output logic             out_tuser,  // [0] is_pixel
  output logic             out_tlast,  // last
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata   // [1:0] pixel_format
);

  srpc_pkg::phase_t                   phase_r, phase_nxt;
  logic [srpc_pkg::WORD_W-1:0]        rows_r, rows_nxt;
  logic [srpc_pkg::WORD_W-1:0]        runs_r, runs_nxt;
  logic [srpc_pkg::WORD_W-1:0]        pix_r, pix_nxt;
  logic [srpc_pkg::FMT_W-1:0]         fmt_r;
  logic                               out_valid_r;
  logic [srpc_pkg::WORD_W-1:0]        out_word_r, out_word_nxt;
  logic                               out_pix_r, out_pix_nxt;
  logic                               out_last_r, out_last_nxt;
  logic                               in_acc;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_pix_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    phase_nxt    = phase_r;
    rows_nxt     = rows_r;
    runs_nxt     = runs_r;
    pix_nxt      = pix_r;
    out_word_nxt = in_tdata;
    out_pix_nxt  = 1'b0;
    out_last_nxt = 1'b0;
    unique case (phase_r) inside
      srpc_pkg::PH_HDR0: phase_nxt = srpc_pkg::PH_HDR1;
      srpc_pkg::PH_HDR1: begin
        rows_nxt  = in_tdata;
        phase_nxt = srpc_pkg::PH_HDR2;
      end
      srpc_pkg::PH_HDR2: phase_nxt = srpc_pkg::PH_HDR3;
      srpc_pkg::PH_HDR3: begin
        if (rows_r == '0) begin
          out_last_nxt = 1'b1;
          phase_nxt    = srpc_pkg::PH_HDR0;
        end else begin
          phase_nxt = srpc_pkg::PH_COUNT;
        end
      end
      srpc_pkg::PH_COUNT: begin
        runs_nxt = in_tdata;
        if (in_tdata == '0) begin
          out_last_nxt = 1'b1;
          phase_nxt    = srpc_pkg::PH_HDR0;
        end else begin
          phase_nxt = srpc_pkg::PH_SIZE;
        end
      end
      srpc_pkg::PH_SIZE, srpc_pkg::PH_PIXEL: begin
        if (phase_r == srpc_pkg::PH_SIZE) begin
          pix_nxt = in_tdata;
        end else begin
          pix_nxt      = pix_r - 16'd1;
          out_pix_nxt  = 1'b1;
          out_word_nxt = srpc_pkg::convert_pixel(in_tdata, fmt_r);
        end
        if (pix_nxt != '0) begin
          phase_nxt = srpc_pkg::PH_PIXEL;
        end else begin
          // close the run, then the row
          runs_nxt = runs_r - 16'd1;
          if (runs_nxt != '0) begin
            phase_nxt = srpc_pkg::PH_LEAD;
          end else begin
            rows_nxt = rows_r - 16'd1;
            if (rows_nxt == '0) begin
              out_last_nxt = 1'b1;
              phase_nxt    = srpc_pkg::PH_HDR0;
            end else begin
              phase_nxt = srpc_pkg::PH_COUNT;
            end
          end
        end
      end
      srpc_pkg::PH_LEAD: phase_nxt = srpc_pkg::PH_SIZE;
      default: phase_nxt = srpc_pkg::PH_HDR0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= srpc_pkg::PH_HDR0;
      rows_r      <= '0;
      runs_r      <= '0;
      pix_r       <= '0;
      fmt_r       <= srpc_pkg::FMT_RGB565;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fmt_r <= cfg_wdata;
      end
      if (in_acc) begin
        phase_r     <= phase_nxt;
        rows_r      <= rows_nxt;
        runs_r      <= runs_nxt;
        pix_r       <= pix_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_word_r <= out_word_nxt;
      out_pix_r  <= out_pix_nxt;
      out_last_r <= out_last_nxt;
    end
  end

`ifndef SYNTH
  a_pixel_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == srpc_pkg::PH_PIXEL |=> out_tvalid && out_tuser)
    else $error("pixel word not flagged");

  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && out_last_nxt |=> phase_r == srpc_pkg::PH_HDR0)
    else $error("parser did not restart after last word");

  a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && fmt_r == srpc_pkg::FMT_RGB565 |=> out_tdata == $past(in_tdata))
    else $error("passthrough word altered");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output");
`endif

endmodule

`default_nettype wire
